>>> design/spa_pkg.sv
// ----------------------------------------------------------------------------
// Sparse polynomial add/subtract package
// Shared types and constants for the term stores, controller and datapath.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int CoefW = 16;
  localparam int ExpW  = 8;
  localparam int ResW  = 17;
  localparam int WordW = CoefW + ExpW;

  typedef logic [1:0]       kind_t;
  typedef logic [CoefW-1:0] coef_t;
  typedef logic [ExpW-1:0]  exp_t;
  typedef logic [ResW-1:0]  res_t;

  localparam kind_t KIND_LOAD_FIRST  = 2'd0;
  localparam kind_t KIND_LOAD_SECOND = 2'd1;
  localparam kind_t KIND_COMPUTE     = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_PIVOT,
    ST_GET_PIVOT,
    ST_COMPARE,
    ST_WR_PIVOT,
    ST_MERGE_RD,
    ST_EMIT
  } spa_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic init_sort;
    logic rd_pivot;
    logic get_pivot;
    logic compare;
    logic wr_pivot;
    logic init_merge;
    logic merge_rd;
    logic emit;
  } spa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sort_needed;
    logic q_last;
    logic p_last;
    logic merge_done;
  } spa_sts_t;

endpackage

>>> design/spa_if.sv
// ----------------------------------------------------------------------------
// Sparse polynomial add/subtract channels
// Valid/ready interfaces for the input items and the result terms.
// ----------------------------------------------------------------------------
interface spa_in_if;
  import spa_pkg::*;
  logic  valid;
  logic  ready;
  kind_t kind;
  coef_t coefficient;
  exp_t  exponent;
  modport source (output valid, kind, coefficient, exponent, input ready);
  modport sink (input valid, kind, coefficient, exponent, output ready);
endinterface

interface spa_out_if;
  import spa_pkg::*;
  logic valid;
  logic ready;
  logic term_valid;
  res_t result_coefficient;
  exp_t result_exponent;
  logic last_term;
  logic overflow_seen;
  modport source (output valid, term_valid, result_coefficient, result_exponent,
                  last_term, overflow_seen, input ready);
  modport sink (input valid, term_valid, result_coefficient, result_exponent,
                last_term, overflow_seen, output ready);
endinterface

>>> design/spa_ram.sv
// ----------------------------------------------------------------------------
// Sparse polynomial term store
// Simple dual-port memory with one write port and a registered read port.
// ----------------------------------------------------------------------------
module spa_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int DW    = 24
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);
  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

>>> design/spa_ctrl.sv
// ----------------------------------------------------------------------------
// Sparse polynomial add/subtract controller
// Sequences loads, the exchange sort of both stores and the merge walk.
// ----------------------------------------------------------------------------
module spa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  spa_pkg::kind_t    kind_i,
  output logic              in_ready_o,
  input  spa_pkg::spa_sts_t sts_i,
  output spa_pkg::spa_cmd_t cmd_o
);
  import spa_pkg::*;

  spa_state_e state_q, state_d;
  logic       accept;

  assign accept = in_valid_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && kind_i == KIND_COMPUTE) begin
          state_d = sts_i.sort_needed ? ST_RD_PIVOT : ST_MERGE_RD;
        end
      end
      ST_RD_PIVOT:  state_d = ST_GET_PIVOT;
      ST_GET_PIVOT: state_d = ST_COMPARE;
      ST_COMPARE: begin
        if (sts_i.q_last) begin
          state_d = ST_WR_PIVOT;
        end
      end
      ST_WR_PIVOT:  state_d = sts_i.p_last ? ST_MERGE_RD : ST_RD_PIVOT;
      ST_MERGE_RD:  state_d = ST_EMIT;
      ST_EMIT: begin
        if (sts_i.merge_done) begin
          state_d = ST_IDLE;
        end
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = accept &&
                     (kind_i == KIND_LOAD_FIRST || kind_i == KIND_LOAD_SECOND);
        if (accept && kind_i == KIND_COMPUTE) begin
          cmd_o.init_sort  = sts_i.sort_needed;
          cmd_o.init_merge = !sts_i.sort_needed;
        end
      end
      ST_RD_PIVOT:  cmd_o.rd_pivot  = 1'b1;
      ST_GET_PIVOT: cmd_o.get_pivot = 1'b1;
      ST_COMPARE:   cmd_o.compare   = 1'b1;
      ST_WR_PIVOT: begin
        cmd_o.wr_pivot   = 1'b1;
        cmd_o.init_merge = sts_i.p_last;
      end
      ST_MERGE_RD:  cmd_o.merge_rd  = 1'b1;
      ST_EMIT:      cmd_o.emit      = 1'b1;
      default:      cmd_o           = '0;
    endcase
  end
endmodule

>>> design/spa_dp.sv
// ----------------------------------------------------------------------------
// Sparse polynomial add/subtract datapath
// Term stores, sort and merge counters, combine arithmetic and output register.
// ----------------------------------------------------------------------------
module spa_dp #(
  parameter int MAX_TERMS = 32,
  parameter int AW        = 5,
  parameter int CW        = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spa_pkg::spa_cmd_t cmd_i,
  output spa_pkg::spa_sts_t sts_o,
  input  spa_pkg::kind_t    kind_i,
  input  spa_pkg::coef_t    coefficient_i,
  input  spa_pkg::exp_t     exponent_i,
  input  logic              subtract_mode_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic              term_valid_o,
  output spa_pkg::res_t     result_coefficient_o,
  output spa_pkg::exp_t     result_exponent_o,
  output logic              last_term_o,
  output logic              overflow_seen_o
);
  import spa_pkg::*;

  logic [CW-1:0]    cnt_q [2];
  logic [CW-1:0]    p_q, q_q, a_q, b_q;
  logic [CW-1:0]    a_d, b_d;
  logic             overflow_q;
  coef_t            cur_c_q [2];
  exp_t             cur_e_q [2];

  logic             we [2];
  logic [AW-1:0]    waddr [2];
  logic [AW-1:0]    raddr [2];
  logic [WordW-1:0] wdata [2];
  logic [WordW-1:0] rdata [2];
  logic             full [2];
  logic             swap [2];

  logic [CW-1:0]    mx;
  logic [CW:0]      q_inc, p_inc;

  logic             out_valid_q, term_valid_q, last_q, ovf_out_q;
  res_t             res_c_q;
  exp_t             res_e_q;

  logic             has_a, has_b, use_a, use_b, last, free;
  res_t             ca, cb, res_c;
  exp_t             e1, e2;

  for (genvar g = 0; g < 2; g++) begin : g_store
    spa_ram #(.DEPTH(MAX_TERMS), .AW(AW), .DW(WordW)) u_ram (
      .clk_i  (clk_i),
      .we_i   (we[g]),
      .waddr_i(waddr[g]),
      .wdata_i(wdata[g]),
      .raddr_i(raddr[g]),
      .rdata_o(rdata[g])
    );
  end

  assign mx    = (cnt_q[0] > cnt_q[1]) ? cnt_q[0] : cnt_q[1];
  assign q_inc = {1'b0, q_q} + 1'b1;
  assign p_inc = {1'b0, p_q} + 1'b1;
  assign free  = !out_valid_q || out_ready_i;

  // Merge step: pick the lower exponent, or combine a matching pair.
  assign e1    = rdata[0][ExpW-1:0];
  assign e2    = rdata[1][ExpW-1:0];
  assign ca    = {rdata[0][WordW-1], rdata[0][WordW-1:ExpW]};
  assign cb    = {rdata[1][WordW-1], rdata[1][WordW-1:ExpW]};
  assign has_a = a_q < cnt_q[0];
  assign has_b = b_q < cnt_q[1];
  assign use_a = has_a && (!has_b || e1 <= e2);
  assign use_b = has_b && (!has_a || e2 <= e1);
  assign a_d   = a_q + CW'(use_a);
  assign b_d   = b_q + CW'(use_b);
  assign last  = (a_d >= cnt_q[0]) && (b_d >= cnt_q[1]);

  always_comb begin
    if (use_a && use_b) begin
      res_c = subtract_mode_i ? (ca - cb) : (ca + cb);
    end else if (use_a) begin
      res_c = ca;
    end else if (use_b) begin
      res_c = subtract_mode_i ? (res_t'(0) - cb) : cb;
    end else begin
      res_c = '0;
    end
  end

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      full[s]  = cnt_q[s] >= CW'(MAX_TERMS);
      swap[s]  = cmd_i.compare && (q_q < cnt_q[s]) &&
                 (cur_e_q[s] > rdata[s][ExpW-1:0]);
      we[s]    = 1'b0;
      waddr[s] = cnt_q[s][AW-1:0];
      wdata[s] = {coefficient_i, exponent_i};
      raddr[s] = p_q[AW-1:0];
      if (cmd_i.load && kind_i[0] == 1'(s) && !full[s]) begin
        we[s] = 1'b1;
      end
      if (cmd_i.get_pivot) begin
        raddr[s] = q_q[AW-1:0];
      end
      if (cmd_i.compare) begin
        raddr[s] = q_inc[AW-1:0];
        we[s]    = swap[s];
        waddr[s] = q_q[AW-1:0];
        wdata[s] = {cur_c_q[s], cur_e_q[s]};
      end
      if (cmd_i.wr_pivot) begin
        we[s]    = p_q < cnt_q[s];
        waddr[s] = p_q[AW-1:0];
        wdata[s] = {cur_c_q[s], cur_e_q[s]};
      end
      if (cmd_i.merge_rd) begin
        raddr[s] = (s == 0) ? a_q[AW-1:0] : b_q[AW-1:0];
      end
      if (cmd_i.emit) begin
        if (free) begin
          raddr[s] = (s == 0) ? a_d[AW-1:0] : b_d[AW-1:0];
        end else begin
          raddr[s] = (s == 0) ? a_q[AW-1:0] : b_q[AW-1:0];
        end
      end
    end
  end

  assign sts_o.sort_needed = mx > CW'(1);
  assign sts_o.q_last      = q_inc >= {1'b0, mx};
  assign sts_o.p_last      = (p_inc + 1'b1) >= {1'b0, mx};
  assign sts_o.merge_done  = cmd_i.emit && free && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q[0]    <= '0;
      cnt_q[1]    <= '0;
      overflow_q  <= 1'b0;
      p_q         <= '0;
      q_q         <= '0;
      a_q         <= '0;
      b_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      for (int s = 0; s < 2; s++) begin
        if (cmd_i.load && kind_i[0] == 1'(s)) begin
          if (full[s]) begin
            overflow_q <= 1'b1;
          end else begin
            cnt_q[s] <= cnt_q[s] + 1'b1;
          end
        end
        if (sts_o.merge_done) begin
          cnt_q[s] <= '0;
        end
      end
      if (cmd_i.init_sort) begin
        p_q <= '0;
      end
      if (cmd_i.rd_pivot) begin
        q_q <= p_inc[CW-1:0];
      end
      if (cmd_i.compare) begin
        q_q <= q_inc[CW-1:0];
      end
      if (cmd_i.wr_pivot) begin
        p_q <= p_inc[CW-1:0];
      end
      if (cmd_i.init_merge) begin
        a_q <= '0;
        b_q <= '0;
      end else if (cmd_i.emit && free) begin
        a_q <= a_d;
        b_q <= b_d;
      end
      if (cmd_i.emit && free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The pivot entry is held here while the rest of the store streams past.
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < 2; s++) begin
      if (cmd_i.get_pivot || swap[s]) begin
        cur_c_q[s] <= rdata[s][WordW-1:ExpW];
        cur_e_q[s] <= rdata[s][ExpW-1:0];
      end
    end
    if (cmd_i.emit && free) begin
      term_valid_q <= use_a || use_b;
      res_c_q      <= res_c;
      res_e_q      <= use_a ? e1 : (use_b ? e2 : '0);
      last_q       <= last;
      ovf_out_q    <= overflow_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign term_valid_o         = term_valid_q;
  assign result_coefficient_o = res_c_q;
  assign result_exponent_o    = res_e_q;
  assign last_term_o          = last_q;
  assign overflow_seen_o      = ovf_out_q;
endmodule

>>> design/sparse_polynomial_add_sub.sv
// ----------------------------------------------------------------------------
// Sparse polynomial add/subtract
// Loads two sparse polynomials, then sorts, merges and streams the result.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on in_i. Kind first or second stores one term in that
// polynomial's store; a load into a full store is dropped and sets the
// sticky overflow flag. Kind compute starts a pass that sorts both stores
// by exponent with an exchange sort, skipped when no store holds two or
// more terms, and then merges them. The sort compares each held pivot with
// the later entries through the store memory read port. The merge first
// primes the memory reads, then emits one result per cycle on out_i while
// out_i does not stall, the last one marked by last_term. A compute on
// two empty stores yields one result with term_valid low. in_i.ready is low
// from compute acceptance until the last result is loaded in the output
// register. A stall on out_i holds the output register and pauses the merge.
// Reset empties both stores, clears the overflow flag and subtract mode.
// Write subtract_mode via cfg_we_i only while the block is idle; unenforced.
module sparse_polynomial_add_sub #(
  parameter int MAX_TERMS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_data_i,
  spa_in_if.sink       in_i,
  spa_out_if.source    out_i
);
  import spa_pkg::*;

  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW = $clog2(MAX_TERMS + 1);

  spa_cmd_t cmd;
  spa_sts_t sts;
  logic     subtract_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subtract_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      subtract_mode_q <= cfg_data_i;
    end
  end

  spa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .kind_i    (in_i.kind),
    .in_ready_o(in_i.ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  spa_dp #(.MAX_TERMS(MAX_TERMS), .AW(AW), .CW(CW)) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .kind_i              (in_i.kind),
    .coefficient_i       (in_i.coefficient),
    .exponent_i          (in_i.exponent),
    .subtract_mode_i     (subtract_mode_q),
    .out_ready_i         (out_i.ready),
    .out_valid_o         (out_i.valid),
    .term_valid_o        (out_i.term_valid),
    .result_coefficient_o(out_i.result_coefficient),
    .result_exponent_o   (out_i.result_exponent),
    .last_term_o         (out_i.last_term),
    .overflow_seen_o     (out_i.overflow_seen)
  );
endmodule

>>> design/spa_checker.sv
// ----------------------------------------------------------------------------
// Sparse polynomial add/subtract checker
// Port-level properties of the block, bound to the top level.
// ----------------------------------------------------------------------------
module spa_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_i,
  input spa_pkg::kind_t kind_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input logic           term_valid_i,
  input logic           last_term_i
);
  import spa_pkg::*;

  // A result waiting for the receiver stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // Accepting a compute closes the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && kind_i == KIND_COMPUTE |=> !in_ready_i)
    else $error("input open after compute");

  // While a compute is still streaming, no new item is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_term_i |-> !in_ready_i)
    else $error("input open during merge");

  // An empty answer is always the only, and so the last, result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !term_valid_i |-> last_term_i)
    else $error("empty result not marked last");
endmodule

bind sparse_polynomial_add_sub spa_checker u_spa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .kind_i      (in_i.kind),
  .out_valid_i (out_i.valid),
  .out_ready_i (out_i.ready),
  .term_valid_i(out_i.term_valid),
  .last_term_i (out_i.last_term)
);
